// ----- rtl/dcba_pkg.sv -----
// shared types and constants of the dual channel block averager
// no dependencies; imported by the controller, the datapath and the top level
`default_nettype none

package dcba_pkg;

    localparam int COUNT_W    = 8;
    localparam int GAIN_W     = 8;
    localparam int AVG_W      = 16;
    localparam int DIGIT_W    = 4;
    localparam int BCD_DIGITS = 5;
    localparam int BCD_W      = BCD_DIGITS * DIGIT_W;
    localparam int BCD_STEPS  = AVG_W;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_AVERAGE_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_VOLTAGE_GAIN  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CURRENT_GAIN  = 2'd2;

    localparam logic [COUNT_W-1:0] AVERAGE_COUNT_RST = 8'd250;
    localparam logic [GAIN_W-1:0]  VOLTAGE_GAIN_RST  = 8'd150;
    localparam logic [GAIN_W-1:0]  CURRENT_GAIN_RST  = 8'd10;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_DIV,
        S_SAT,
        S_BCD,
        S_OUT
    } t_state;

    typedef struct packed {
        logic accum;
        logic start;
        logic mul;
        logic div_step;
        logic bcd_load;
        logic bcd_step;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic hit;
        logic out_free;
    } t_stat;

endpackage

`default_nettype wire

// ----- rtl/dcba_ctrl.sv -----
// sequencing controller: accumulate, multiply, divide, saturate, bcd convert, output
// depends on dcba_pkg for the state type and the command and status structs
`default_nettype none

module dcba_ctrl #(
    parameter int SAMPLE_BITS = 10
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output logic                o_in_ready,
    input  dcba_pkg::t_stat     i_stat,
    output dcba_pkg::t_cmd      o_cmd
);
    import dcba_pkg::*;

    localparam int QW        = SAMPLE_BITS + COUNT_W + GAIN_W - 2;
    localparam int DIV_STEPS = (QW + 1) / 2;
    localparam int MAX_STEPS = (DIV_STEPS > BCD_STEPS) ? DIV_STEPS : BCD_STEPS;
    localparam int STEP_W    = $clog2(MAX_STEPS);
    localparam logic [STEP_W-1:0] DIV_LAST = STEP_W'(DIV_STEPS - 1);
    localparam logic [STEP_W-1:0] BCD_LAST = STEP_W'(BCD_STEPS - 1);

    t_state r_state, n_state;
    logic [STEP_W-1:0] r_step, n_step;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid && i_stat.hit) begin
                    n_state = S_MUL;
                end
            end
            S_MUL: n_state = S_DIV;
            S_DIV: begin
                if (r_step == DIV_LAST) begin
                    n_state = S_SAT;
                end
            end
            S_SAT: n_state = S_BCD;
            S_BCD: begin
                if (r_step == BCD_LAST) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (i_stat.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
        n_step = (n_state != r_state) ? '0 : r_step + 1'b1;
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready  = 1'b1;
                o_cmd.accum = i_in_valid;
                o_cmd.start = i_in_valid && i_stat.hit;
            end
            S_MUL: o_cmd.mul = 1'b1;
            S_DIV: o_cmd.div_step = 1'b1;
            S_SAT: o_cmd.bcd_load = 1'b1;
            S_BCD: o_cmd.bcd_step = 1'b1;
            S_OUT: o_cmd.out_load = i_stat.out_free;
            default: o_cmd = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    a_mul_to_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MUL) |=> (r_state == S_DIV))
        else $error("multiply not followed by divide");

    a_div_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV && r_step == DIV_LAST) |=> (r_state == S_SAT))
        else $error("divider ran past its last step");

    a_out_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |=> (r_state == S_IDLE && o_in_ready))
        else $error("input not reopened after result load");

endmodule

`default_nettype wire

// ----- rtl/dcba_datapath.sv -----
// datapath: channel accumulators, gain multiplier, radix-4 restoring divider,
// double dabble bcd converter and output register; depends on dcba_pkg
`default_nettype none

module dcba_datapath #(
    parameter int SAMPLE_BITS = 10
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  dcba_pkg::t_cmd                       i_cmd,
    output dcba_pkg::t_stat                      o_stat,
    input  wire logic [SAMPLE_BITS-1:0]          i_sample,
    input  wire logic [dcba_pkg::COUNT_W-1:0]    i_average_count,
    input  wire logic [dcba_pkg::GAIN_W-1:0]     i_voltage_gain,
    input  wire logic [dcba_pkg::GAIN_W-1:0]     i_current_gain,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_ready,
    output logic                                 o_is_voltage,
    output logic [dcba_pkg::AVG_W-1:0]           o_average,
    output logic [dcba_pkg::DIGIT_W-1:0]         o_digit_high,
    output logic [dcba_pkg::DIGIT_W-1:0]         o_digit_mid,
    output logic [dcba_pkg::DIGIT_W-1:0]         o_digit_low
);
    import dcba_pkg::*;

    localparam int SUM_W     = SAMPLE_BITS + COUNT_W;
    localparam int PROD_W    = SUM_W + GAIN_W;
    localparam int QW        = PROD_W - 2;
    localparam int DIV_STEPS = (QW + 1) / 2;
    localparam int QP        = 2 * DIV_STEPS;
    localparam int DIV_W     = COUNT_W + 1;

    // channel accumulators
    logic               r_next_volt;
    logic [SUM_W-1:0]   r_vsum, r_csum;
    logic [COUNT_W-1:0] r_vcnt, r_ccnt;

    // operands of the block being finished
    logic [SUM_W-1:0]   r_op_sum;
    logic [GAIN_W-1:0]  r_op_gain;
    logic [DIV_W-1:0]   r_op_div;
    logic               r_op_volt;

    logic [QP-1:0]      r_dq, n_dq;
    logic [DIV_W-1:0]   r_rem, n_rem;
    logic [AVG_W-1:0]   r_bin, r_avg, n_bin;
    logic [BCD_W-1:0]   r_bcd, n_bcd;

    logic               r_out_valid;
    logic               r_out_volt;
    logic [AVG_W-1:0]   r_out_avg;
    logic [DIGIT_W-1:0] r_out_high, r_out_mid, r_out_low;

    logic [SUM_W-1:0]   sum_new;
    logic [COUNT_W-1:0] cnt_new;
    logic [PROD_W-1:0]  prod;
    logic               over;

    assign sum_new = (r_next_volt ? r_vsum : r_csum) + SUM_W'(i_sample);
    assign cnt_new = (r_next_volt ? r_vcnt : r_ccnt) + 1'b1;
    assign prod    = r_op_sum * r_op_gain;
    assign over    = |r_dq[QP-1:AVG_W];

    assign o_stat.hit      = (cnt_new == i_average_count);
    assign o_stat.out_free = !r_out_valid || i_out_ready;

    // two restoring quotient bits per cycle
    always_comb begin
        logic [DIV_W:0] rem_sh;
        logic [DIV_W:0] diff;
        n_rem = r_rem;
        n_dq  = r_dq;
        for (int k = 0; k < 2; k++) begin
            rem_sh = {n_rem, n_dq[QP-1]};
            diff   = rem_sh - {1'b0, r_op_div};
            if (rem_sh >= {1'b0, r_op_div}) begin
                n_rem = diff[DIV_W-1:0];
                n_dq  = {n_dq[QP-2:0], 1'b1};
            end else begin
                n_rem = rem_sh[DIV_W-1:0];
                n_dq  = {n_dq[QP-2:0], 1'b0};
            end
        end
    end

    // add 3 to every digit of 5 or more, then shift in the next binary bit
    always_comb begin
        logic [BCD_W-1:0] adj;
        adj = r_bcd;
        for (int d = 0; d < BCD_DIGITS; d++) begin
            if (adj[d*DIGIT_W +: DIGIT_W] >= DIGIT_W'(5)) begin
                adj[d*DIGIT_W +: DIGIT_W] = adj[d*DIGIT_W +: DIGIT_W] + DIGIT_W'(3);
            end
        end
        n_bcd = {adj[BCD_W-2:0], r_bin[AVG_W-1]};
        n_bin = {r_bin[AVG_W-2:0], 1'b0};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_next_volt <= 1'b0;
            r_vsum      <= '0;
            r_csum      <= '0;
            r_vcnt      <= '0;
            r_ccnt      <= '0;
        end else if (i_cmd.accum) begin
            r_next_volt <= !r_next_volt;
            if (r_next_volt) begin
                r_vsum <= o_stat.hit ? '0 : sum_new;
                r_vcnt <= o_stat.hit ? '0 : cnt_new;
            end else begin
                r_csum <= o_stat.hit ? '0 : sum_new;
                r_ccnt <= o_stat.hit ? '0 : cnt_new;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_op_sum  <= sum_new;
            r_op_gain <= r_next_volt ? i_voltage_gain : i_current_gain;
            // a count of zero stands for 256
            r_op_div  <= {cnt_new == '0, cnt_new};
            r_op_volt <= r_next_volt;
        end
        if (i_cmd.mul) begin
            r_dq  <= QP'(prod[PROD_W-1:2]);
            r_rem <= '0;
        end else if (i_cmd.div_step) begin
            r_dq  <= n_dq;
            r_rem <= n_rem;
        end
        if (i_cmd.bcd_load) begin
            r_bin <= over ? '1 : r_dq[AVG_W-1:0];
            r_avg <= over ? '1 : r_dq[AVG_W-1:0];
            r_bcd <= '0;
        end else if (i_cmd.bcd_step) begin
            r_bin <= n_bin;
            r_bcd <= n_bcd;
        end
        if (i_cmd.out_load) begin
            r_out_volt <= r_op_volt;
            r_out_avg  <= r_avg;
            if (r_op_volt) begin
                r_out_high <= r_bcd[4*DIGIT_W +: DIGIT_W];
                r_out_mid  <= r_bcd[3*DIGIT_W +: DIGIT_W];
                r_out_low  <= r_bcd[2*DIGIT_W +: DIGIT_W];
            end else begin
                r_out_high <= r_bcd[3*DIGIT_W +: DIGIT_W];
                r_out_mid  <= r_bcd[2*DIGIT_W +: DIGIT_W];
                r_out_low  <= r_bcd[1*DIGIT_W +: DIGIT_W];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_is_voltage = r_out_volt;
    assign o_average    = r_out_avg;
    assign o_digit_high = r_out_high;
    assign o_digit_mid  = r_out_mid;
    assign o_digit_low  = r_out_low;

    a_digits_decimal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_digit_high <= DIGIT_W'(9) && o_digit_mid <= DIGIT_W'(9)
                         && o_digit_low <= DIGIT_W'(9)))
        else $error("result digit out of decimal range");

    a_load_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |=> o_out_valid)
        else $error("loaded result not presented");

    a_divisor_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.start |=> (r_op_div != '0))
        else $error("divisor captured as zero");

endmodule

`default_nettype wire

// ----- rtl/dual_channel_block_averager.sv -----
// dual channel block averager: a beat that does not finish a block leaves input ready high;
// a beat that finishes one holds input ready low while the block result is built and until
// the output register is free; the result is built by a multiply, a divide at 2 quotient
// bits per divider cycle, a saturate, the bcd shift steps and an output load. synchronous
// active low reset clears sums, counts and the channel flag (current first) and restores
// the three registers
`default_nettype none

module dual_channel_block_averager #(
    parameter int SAMPLE_BITS = 10
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_in_valid,
    output logic                                   o_in_ready,
    input  wire logic [SAMPLE_BITS-1:0]            i_sample,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_ready,
    output logic                                   o_is_voltage,
    output logic [dcba_pkg::AVG_W-1:0]             o_average,
    output logic [dcba_pkg::DIGIT_W-1:0]           o_digit_high,
    output logic [dcba_pkg::DIGIT_W-1:0]           o_digit_mid,
    output logic [dcba_pkg::DIGIT_W-1:0]           o_digit_low,
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [dcba_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [dcba_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import dcba_pkg::*;

    logic [COUNT_W-1:0] r_average_count;
    logic [GAIN_W-1:0]  r_voltage_gain;
    logic [GAIN_W-1:0]  r_current_gain;

    t_cmd  cmd;
    t_stat stat;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_average_count <= AVERAGE_COUNT_RST;
            r_voltage_gain  <= VOLTAGE_GAIN_RST;
            r_current_gain  <= CURRENT_GAIN_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_AVERAGE_COUNT: r_average_count <= i_cfg_data;
                CFG_VOLTAGE_GAIN:  r_voltage_gain  <= i_cfg_data;
                CFG_CURRENT_GAIN:  r_current_gain  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    dcba_ctrl #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    dcba_datapath #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .i_sample        (i_sample),
        .i_average_count (r_average_count),
        .i_voltage_gain  (r_voltage_gain),
        .i_current_gain  (r_current_gain),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_is_voltage    (o_is_voltage),
        .o_average       (o_average),
        .o_digit_high    (o_digit_high),
        .o_digit_mid     (o_digit_mid),
        .o_digit_low     (o_digit_low)
    );

endmodule

`default_nettype wire

// ----- sim/dual_channel_block_averager_tb.sv -----
`timescale 1ns / 100ps
// self-checking bench for the dual channel block averager: random samples in, block readings
// checked against an in-bench model of the two channel sums; depends on rtl/dcba_pkg.sv
// and rtl/dual_channel_block_averager.sv

module dual_channel_block_averager_tb;
    import dcba_pkg::*;

    localparam int SAMPLE_W     = 10;
    localparam int SUM_W        = SAMPLE_W + COUNT_W;
    localparam int PROD_W       = SUM_W + GAIN_W;
    localparam int SETTLE_CYCLES = 40;
    localparam int TIMEOUT_NS   = 3_000_000;
    localparam int REPORT_MAX   = 10;

    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 2'd3;

    typedef struct packed {
        logic               is_voltage;
        logic [AVG_W-1:0]   average;
        logic [DIGIT_W-1:0] high;
        logic [DIGIT_W-1:0] mid;
        logic [DIGIT_W-1:0] low;
    } t_reading;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_ready;
    logic [SAMPLE_W-1:0]   i_sample = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    logic                  o_is_voltage;
    logic [AVG_W-1:0]      o_average;
    logic [DIGIT_W-1:0]    o_digit_high;
    logic [DIGIT_W-1:0]    o_digit_mid;
    logic [DIGIT_W-1:0]    o_digit_low;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    // model of the block: channel flag, sums, counts and the three registers
    logic                 volt_next = 1'b0;
    logic [SUM_W-1:0]     volt_sum = '0;
    logic [SUM_W-1:0]     curr_sum = '0;
    logic [COUNT_W-1:0]   volt_cnt = '0;
    logic [COUNT_W-1:0]   curr_cnt = '0;
    logic [COUNT_W-1:0]   block_len = AVERAGE_COUNT_RST;
    logic [GAIN_W-1:0]    volt_gain = VOLTAGE_GAIN_RST;
    logic [GAIN_W-1:0]    curr_gain = CURRENT_GAIN_RST;

    logic [SAMPLE_W-1:0]  sample_queue[$];
    t_reading             expected_readings[$];
    t_reading             got;
    t_reading             want;

    bit  in_taken = 1'b0;
    bit  no_idle = 1'b0;
    int  samples_pushed = 0;
    int  samples_sent = 0;
    int  readings_checked = 0;
    int  volt_readings = 0;
    int  saturated_readings = 0;
    int  fail_count = 0;

    dual_channel_block_averager #(
        .SAMPLE_BITS(SAMPLE_W)
    ) u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_sample     (i_sample),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_is_voltage (o_is_voltage),
        .o_average    (o_average),
        .o_digit_high (o_digit_high),
        .o_digit_mid  (o_digit_mid),
        .o_digit_low  (o_digit_low),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // adds one sample to its channel and queues the block reading if the block closes
    function automatic void accumulate_sample(input logic [SAMPLE_W-1:0] s);
        logic [SUM_W-1:0]   sum;
        logic [COUNT_W-1:0] cnt;
        logic [GAIN_W-1:0]  gain;
        logic [10:0]        divisor;
        logic [PROD_W-1:0]  product;
        logic [PROD_W-1:0]  quotient;
        logic [AVG_W-1:0]   avg;
        int unsigned        a;
        t_reading           r;
        if (volt_next) begin
            volt_sum = volt_sum + SUM_W'(s);
            volt_cnt = volt_cnt + 1'b1;
            sum      = volt_sum;
            cnt      = volt_cnt;
            gain     = volt_gain;
        end else begin
            curr_sum = curr_sum + SUM_W'(s);
            curr_cnt = curr_cnt + 1'b1;
            sum      = curr_sum;
            cnt      = curr_cnt;
            gain     = curr_gain;
        end
        r.is_voltage = volt_next;
        volt_next    = !volt_next;
        if (cnt != block_len) return;

        // a count of zero means the count wrapped after 256 samples
        divisor  = (cnt == '0) ? 11'd1024 : {1'b0, cnt, 2'b00};
        product  = sum * gain;
        quotient = product / divisor;
        avg      = (quotient > PROD_W'(16'hFFFF)) ? '1 : quotient[AVG_W-1:0];
        a        = avg;
        r.average = avg;
        if (r.is_voltage) begin
            r.high   = DIGIT_W'((a / 10000) % 10);
            r.mid    = DIGIT_W'((a / 1000) % 10);
            r.low    = DIGIT_W'((a / 100) % 10);
            volt_sum = '0;
            volt_cnt = '0;
        end else begin
            r.high   = DIGIT_W'((a / 1000) % 10);
            r.mid    = DIGIT_W'((a / 100) % 10);
            r.low    = DIGIT_W'((a / 10) % 10);
            curr_sum = '0;
            curr_cnt = '0;
        end
        expected_readings.push_back(r);
    endfunction

    function automatic void push_sample(input logic [SAMPLE_W-1:0] s);
        sample_queue.push_back(s);
        samples_pushed++;
    endfunction

    function automatic logic [SAMPLE_W-1:0] random_sample();
        case ($urandom_range(9))
            0: return '0;
            1: return '1;
            2: return SAMPLE_W'(1) << $urandom_range(SAMPLE_W - 1);
            3: return ~(SAMPLE_W'(1) << $urandom_range(SAMPLE_W - 1));
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    function automatic logic [GAIN_W-1:0] random_gain();
        case ($urandom_range(6))
            0: return '0;
            1: return '1;
            default: return GAIN_W'($urandom);
        endcase
    endfunction

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        forever begin
            @(posedge i_clk);
            if (o_cfg_ready) break;
        end
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (sample_queue.size() != 0 || i_in_valid || expected_readings.size() != 0)
            @(posedge i_clk);
        // every predicted reading has been taken here; idle before the next register writes
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // sample driver and output stall
    always @(negedge i_clk) begin
        if (i_rst_n && (!i_in_valid || in_taken)) begin
            if (sample_queue.size() != 0 && (no_idle || $urandom_range(99) >= 37)) begin
                i_sample   <= sample_queue.pop_front();
                i_in_valid <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
        i_out_ready <= no_idle || ($urandom_range(99) >= 37);
    end

    // monitor: checks readings, predicts from accepted samples, tracks register writes
    always @(posedge i_clk) begin
        in_taken = i_rst_n && i_in_valid && o_in_ready;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                got = {o_is_voltage, o_average, o_digit_high, o_digit_mid, o_digit_low};
                readings_checked++;
                if (expected_readings.size() == 0) begin
                    fail_count++;
                    if (fail_count <= REPORT_MAX)
                        $display("unexpected reading: volt=%0d avg=%0d digits=%0d%0d%0d",
                                 got.is_voltage, got.average, got.high, got.mid, got.low);
                end else begin
                    want = expected_readings.pop_front();
                    if (got.is_voltage !== want.is_voltage || got.average !== want.average ||
                        got.high !== want.high || got.mid !== want.mid ||
                        got.low !== want.low) begin
                        fail_count++;
                        if (fail_count <= REPORT_MAX)
                            $display("reading %0d mismatch: exp volt=%0d avg=%0d digits=%0d%0d%0d, got volt=%0d avg=%0d digits=%0d%0d%0d",
                                     readings_checked, want.is_voltage, want.average,
                                     want.high, want.mid, want.low, got.is_voltage,
                                     got.average, got.high, got.mid, got.low);
                    end
                    if (want.is_voltage) volt_readings++;
                    if (want.average == '1) saturated_readings++;
                end
            end
            if (in_taken) begin
                samples_sent++;
                accumulate_sample(i_sample);
            end
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_AVERAGE_COUNT: block_len = i_cfg_data;
                    CFG_VOLTAGE_GAIN:  volt_gain = i_cfg_data;
                    CFG_CURRENT_GAIN:  curr_gain = i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    initial begin
        #(TIMEOUT_NS);
        $display("dual_channel_block_averager_tb: done, errors");
        $finish;
    end

    initial begin
        int avg_len;
        int reps;
        int stop_at;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // long blocks at the reset register values, no idle cycles on either side.
        // voltage samples stay high so its long block saturates without sum wrap
        no_idle = 1'b1;
        repeat (2 * (AVERAGE_COUNT_RST - 1))
            push_sample(samples_pushed[0] ? SAMPLE_W'($urandom_range(960, 1010))
                                          : random_sample());
        wait_drained();
        // block length zero: current closes after 256 samples, voltage stops at 255
        write_register(CFG_AVERAGE_COUNT, 8'd0);
        repeat (13)
            push_sample(samples_pushed[0] ? SAMPLE_W'($urandom_range(960, 1010))
                                          : random_sample());
        wait_drained();
        // block length lowered below the voltage count: it runs through 0 and matches at 1
        write_register(CFG_AVERAGE_COUNT, 8'd1);
        repeat (3)
            push_sample(samples_pushed[0] ? SAMPLE_W'($urandom_range(960, 1010))
                                          : random_sample());
        wait_drained();
        no_idle = 1'b0;

        // one sample per block: extremes and alternating bit patterns
        write_register(CFG_AVERAGE_COUNT, 8'd1);
        write_register(CFG_VOLTAGE_GAIN, 8'd255);
        write_register(CFG_CURRENT_GAIN, 8'd255);
        push_sample('0);
        push_sample('0);
        push_sample('1);
        push_sample('1);
        push_sample(10'h155);
        push_sample(10'h2AA);
        push_sample(10'h2AA);
        push_sample(10'h155);
        push_sample(10'd1);
        push_sample(10'd512);
        wait_drained();
        write_register(CFG_VOLTAGE_GAIN, 8'd0);
        write_register(CFG_CURRENT_GAIN, 8'd0);
        push_sample('1);
        push_sample('1);
        wait_drained();
        // a write past the register list must leave the block length alone
        write_register(CFG_VOLTAGE_GAIN, 8'd255);
        write_register(CFG_CURRENT_GAIN, 8'd255);
        write_register(CFG_UNMAPPED, 8'd2);
        push_sample('1);
        push_sample(10'd700);
        push_sample(10'd999);
        push_sample(10'd1);
        wait_drained();
        write_register(CFG_AVERAGE_COUNT, 8'd2);
        repeat (4) push_sample('1);
        wait_drained();

        // random settings with short blocks; whole blocks keep both counts aligned
        stop_at = samples_pushed + 360;
        while (samples_pushed < stop_at) begin
            case ($urandom_range(9))
                0, 1, 2, 3, 4, 5: avg_len = $urandom_range(1, 4);
                6, 7, 8:          avg_len = $urandom_range(5, 16);
                default:          avg_len = $urandom_range(17, 48);
            endcase
            reps = $urandom_range(1, 3);
            write_register(CFG_VOLTAGE_GAIN, random_gain());
            write_register(CFG_CURRENT_GAIN, random_gain());
            write_register(CFG_AVERAGE_COUNT, CFG_DATA_W'(avg_len));
            if ($urandom_range(3) == 0) write_register(CFG_UNMAPPED, CFG_DATA_W'($urandom));
            repeat (2 * avg_len * reps) push_sample(random_sample());
            wait_drained();
        end

        fail_count += expected_readings.size();
        $display("run covered %0d samples and %0d readings (%0d voltage, %0d saturated)",
                 samples_sent, readings_checked, volt_readings, saturated_readings);
        $display("%0d failing checks", fail_count);
        if (fail_count == 0) begin
            $display("dual_channel_block_averager_tb: done, clean");
        end else begin
            $display("dual_channel_block_averager_tb: done, errors");
        end
        $finish;
    end

endmodule
